[design/bpm_pkg.sv]
package bpm_pkg;

	localparam int unsigned VAL_W = 30;
	localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
	localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;
	localparam int unsigned EBIT_W = 5;
	// Barrett reduction: the quotient estimate is one bit wider than a residue,
	// and the partial remainder stays below three times the modulus.
	localparam int unsigned MU_W = VAL_W + 1;
	localparam int unsigned RED_W = VAL_W + 2;
	localparam logic [MU_W-1:0] BARRETT_MU = MU_W'(64'h1000_0000_0000_0000 / 64'(MODULUS));

	typedef enum logic [1:0] {
		REQ_BUILD = 2'd0,
		REQ_COMB = 2'd1,
		REQ_PERM = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_QUOT,
		MM_BACK,
		MM_FIX
	} mm_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FWD_GO,
		ST_FWD_WAIT,
		ST_PM_GO,
		ST_PM_WAIT,
		ST_PS_GO,
		ST_PS_WAIT,
		ST_BWD_GO,
		ST_BWD_WAIT,
		ST_Q_RD1,
		ST_Q_RD2,
		ST_Q1_GO,
		ST_Q1_WAIT,
		ST_Q2_GO,
		ST_Q2_WAIT,
		ST_Q3_GO,
		ST_Q3_WAIT,
		ST_OUT
	} state_t;

endpackage

[design/bpm_modmul.sv]
module bpm_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bpm_pkg::VAL_W-1:0] op_a,
	input  logic [bpm_pkg::VAL_W-1:0] op_b,
	output logic                      done,
	output logic [bpm_pkg::VAL_W-1:0] product
);
	import bpm_pkg::*;

	mm_state_t state_q, state_d;
	logic [2*VAL_W-1:0] prod_q;
	logic [MU_W-1:0] quot_q;
	logic [RED_W-1:0] rem_q, fix1, fix2;
	logic [MU_W-1:0] mul_x, mul_y;
	logic [2*MU_W-1:0] mul_p;

	// One multiplier serves all three steps of a Barrett reduction: the
	// operand product, the quotient estimate and the quotient times the modulus.
	always_comb begin
		mul_x = MU_W'(op_a);
		mul_y = MU_W'(op_b);
		unique case (state_q)
			MM_QUOT: begin
				mul_x = prod_q[2*VAL_W-1:VAL_W-1];
				mul_y = BARRETT_MU;
			end
			MM_BACK: begin
				mul_x = quot_q;
				mul_y = MU_W'(MODULUS);
			end
			default: ;
		endcase
		mul_p = mul_x * mul_y;
	end

	// The estimate is at most two below the true quotient.
	always_comb begin
		fix1 = (rem_q >= RED_W'(MODULUS)) ? rem_q - RED_W'(MODULUS) : rem_q;
		fix2 = (fix1 >= RED_W'(MODULUS)) ? fix1 - RED_W'(MODULUS) : fix1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MM_IDLE: begin
				if (start) begin
					state_d = MM_QUOT;
				end
			end
			MM_QUOT: state_d = MM_BACK;
			MM_BACK: state_d = MM_FIX;
			MM_FIX: state_d = MM_IDLE;
			default: state_d = MM_IDLE;
		endcase
	end

	assign done = (state_q == MM_FIX);
	assign product = fix2[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MM_IDLE: prod_q <= mul_p[2*VAL_W-1:0];
			MM_QUOT: quot_q <= mul_p[2*MU_W-1:MU_W];
			MM_BACK: rem_q <= prod_q[RED_W-1:0] - mul_p[RED_W-1:0];
			default: ;
		endcase
	end

endmodule

[design/binomial_permutation_mod_prime.sv]
// Answers nCk (req_type 1) and nPk (req_type 2) modulo 1000000007 from a
// factorial table and an inverse-factorial table, each TABLE_DEPTH words deep.
// A build request (req_type 0) must come first: it fills the factorials
// forward, inverts the top factorial by Fermat exponentiation, then fills the
// inverse factorials backward. A query before any build returns status 1 and
// result 0; k greater than n, or n beyond the table, returns 0. Every input
// word yields exactly one output word. All arithmetic goes through a single
// modular multiplier whose steps are the 30x30 product, a Barrett quotient
// estimate, the subtraction of quotient times modulus, and at most two final
// corrections. An nPk query needs one product more than an nCk query. A word
// that needs no table lookup (no tables yet, k greater than n, n beyond the
// table, or the unused code) goes straight from idle to the output step. A
// full output register that stays stalled holds the block in its output step.
// The block takes one word at a time; in_stall stays high until the result
// word has been placed in the output register, which can hold a word while
// the next input word is accepted.
module binomial_permutation_mod_prime #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [11:0] n_value,
	input  logic [11:0] k_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] result_value,
	output logic        status
);
	import bpm_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] TOP_IDX = AW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [VAL_W-1:0] fact_mem [TABLE_DEPTH];
	logic [VAL_W-1:0] inv_mem [TABLE_DEPTH];
	logic [VAL_W-1:0] fact_rd_q, inv_rd_q;
	logic [AW-1:0] fact_raddr, inv_raddr, fact_waddr, inv_waddr;
	logic [VAL_W-1:0] fact_wdata, inv_wdata;
	logic fact_we, inv_we;

	logic [1:0] req_q;
	logic [11:0] n_q, k_q;
	logic [AW-1:0] idx_q;
	logic [EBIT_W-1:0] ebit_q;
	logic [VAL_W-1:0] acc_q, sq_q, pw_q, fn_q, ik_q, fk_q, inmk_q, res_q;
	logic st_q, ready_q, out_valid_q;
	logic [VAL_W-1:0] out_res_q;
	logic out_st_q;

	logic mm_start, mm_done;
	logic [VAL_W-1:0] mm_a, mm_b, mm_res;
	logic in_acc, out_free, query_bad;

	bpm_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.done    (mm_done),
		.product (mm_res)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign result_value = out_res_q;
	assign status = out_st_q;
	assign query_bad = (32'(n_value) >= 32'(TABLE_DEPTH)) || (k_value > n_value);

	// Next state, multiplier operands and table ports.
	always_comb begin
		state_d = state_q;
		mm_start = 1'b0;
		mm_a = acc_q;
		mm_b = VAL_W'(idx_q);
		fact_we = 1'b0;
		fact_waddr = idx_q;
		fact_wdata = mm_res;
		inv_we = 1'b0;
		inv_waddr = idx_q - AW'(1);
		inv_wdata = mm_res;
		fact_raddr = (state_q == ST_Q_RD1) ? AW'(n_q) : AW'(k_q);
		inv_raddr = (state_q == ST_Q_RD1) ? AW'(k_q) : AW'(n_q - k_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (req_type)
						REQ_BUILD: begin
							fact_we = 1'b1;
							fact_waddr = '0;
							fact_wdata = VAL_W'(1);
							state_d = ST_FWD_GO;
						end
						REQ_COMB, REQ_PERM: begin
							state_d = (ready_q && !query_bad) ? ST_Q_RD1 : ST_OUT;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_FWD_GO: begin
				mm_start = 1'b1;
				state_d = ST_FWD_WAIT;
			end
			ST_FWD_WAIT: begin
				if (mm_done) begin
					fact_we = 1'b1;
					state_d = (idx_q == TOP_IDX) ? ST_PM_GO : ST_FWD_GO;
				end
			end
			ST_PM_GO: begin
				mm_a = pw_q;
				mm_b = sq_q;
				if (FERMAT_EXP[ebit_q]) begin
					mm_start = 1'b1;
					state_d = ST_PM_WAIT;
				end else begin
					state_d = ST_PS_GO;
				end
			end
			ST_PM_WAIT: begin
				mm_a = pw_q;
				mm_b = sq_q;
				if (mm_done) begin
					state_d = ST_PS_GO;
				end
			end
			ST_PS_GO: begin
				mm_a = sq_q;
				mm_b = sq_q;
				mm_start = 1'b1;
				state_d = ST_PS_WAIT;
			end
			ST_PS_WAIT: begin
				mm_a = sq_q;
				mm_b = sq_q;
				if (mm_done) begin
					if (ebit_q == EBIT_W'(VAL_W - 1)) begin
						inv_we = 1'b1;
						inv_waddr = TOP_IDX;
						inv_wdata = pw_q;
						state_d = ST_BWD_GO;
					end else begin
						state_d = ST_PM_GO;
					end
				end
			end
			ST_BWD_GO: begin
				mm_start = 1'b1;
				state_d = ST_BWD_WAIT;
			end
			ST_BWD_WAIT: begin
				if (mm_done) begin
					inv_we = 1'b1;
					state_d = (idx_q == AW'(1)) ? ST_OUT : ST_BWD_GO;
				end
			end
			ST_Q_RD1: state_d = ST_Q_RD2;
			ST_Q_RD2: state_d = ST_Q1_GO;
			ST_Q1_GO, ST_Q1_WAIT: begin
				mm_a = fn_q;
				mm_b = ik_q;
				mm_start = (state_q == ST_Q1_GO);
				if (state_q == ST_Q1_GO) begin
					state_d = ST_Q1_WAIT;
				end else if (mm_done) begin
					state_d = ST_Q2_GO;
				end
			end
			ST_Q2_GO, ST_Q2_WAIT: begin
				mm_a = res_q;
				mm_b = inmk_q;
				mm_start = (state_q == ST_Q2_GO);
				if (state_q == ST_Q2_GO) begin
					state_d = ST_Q2_WAIT;
				end else if (mm_done) begin
					state_d = (req_q == REQ_PERM && mm_res != '0) ? ST_Q3_GO : ST_OUT;
				end
			end
			ST_Q3_GO, ST_Q3_WAIT: begin
				mm_a = res_q;
				mm_b = fk_q;
				mm_start = (state_q == ST_Q3_GO);
				if (state_q == ST_Q3_GO) begin
					state_d = ST_Q3_WAIT;
				end else if (mm_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BWD_WAIT && mm_done && idx_q == AW'(1)) begin
				ready_q <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q <= req_type;
				n_q <= n_value;
				k_q <= k_value;
				res_q <= '0;
				st_q <= (req_type == REQ_COMB || req_type == REQ_PERM) && !ready_q;
				acc_q <= VAL_W'(1);
				idx_q <= AW'(1);
			end
			ST_FWD_WAIT: begin
				if (mm_done) begin
					acc_q <= mm_res;
					if (idx_q == TOP_IDX) begin
						sq_q <= mm_res;
						pw_q <= VAL_W'(1);
						ebit_q <= '0;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
			end
			ST_PM_WAIT: begin
				if (mm_done) begin
					pw_q <= mm_res;
				end
			end
			ST_PS_WAIT: begin
				if (mm_done) begin
					sq_q <= mm_res;
					ebit_q <= ebit_q + EBIT_W'(1);
					acc_q <= pw_q;
				end
			end
			ST_BWD_WAIT: begin
				if (mm_done) begin
					acc_q <= mm_res;
					idx_q <= idx_q - AW'(1);
				end
			end
			ST_Q_RD2: begin
				fn_q <= fact_rd_q;
				ik_q <= inv_rd_q;
			end
			ST_Q1_GO: begin
				fk_q <= fact_rd_q;
				inmk_q <= inv_rd_q;
			end
			ST_Q1_WAIT, ST_Q2_WAIT, ST_Q3_WAIT: begin
				if (mm_done) begin
					res_q <= mm_res;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_res_q <= res_q;
					out_st_q <= st_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fact_we) begin
			fact_mem[fact_waddr] <= fact_wdata;
		end
		fact_rd_q <= fact_mem[fact_raddr];
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_waddr] <= inv_wdata;
		end
		inv_rd_q <= inv_mem[inv_raddr];
	end

	// Once built, the tables stay valid.
	assert property (@(posedge clk) disable iff (!arst_n) ready_q |=> ready_q)
		else $error("tables_ready dropped");

	// A not-ready status always carries a zero answer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_value == '0)
		else $error("nonzero answer with not-ready status");

	// Every answer is a reduced residue.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_value < MODULUS)
		else $error("answer not reduced");

	// The multiplier finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_FWD_WAIT || state_q == ST_PM_WAIT ||
			state_q == ST_PS_WAIT || state_q == ST_BWD_WAIT ||
			state_q == ST_Q1_WAIT || state_q == ST_Q2_WAIT || state_q == ST_Q3_WAIT))
		else $error("multiplier result with no waiting step");

endmodule

[bench/tb_top.sv]
// Testbench for binomial_permutation_mod_prime.
//
// Every input word is scored against a prediction made inside this file. The
// prediction keeps its own factorial and inverse-factorial tables, computed
// once at time zero, and its own "tables built" flag. That flag is set when a
// build word is accepted. Each accepted output word is compared, field by
// field, with the oldest prediction still waiting.
//
// A build walks the full 4096-entry table through the shared multiplier, so the
// run issues only two builds:
// - the first build, after the not-ready words have been checked;
// - one repeated build, near the end.
// All other words are queries, or the unused request code, with fixed edge
// values or random content.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpm_pkg::*;

	localparam int unsigned DEPTH = 4096;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [11:0] n_value;
	logic [11:0] k_value;
	logic        out_valid;
	logic        out_stall;
	logic [29:0] result_value;
	logic        status;

	binomial_permutation_mod_prime #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.n_value(n_value),
		.k_value(k_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status)
	);

	typedef struct packed {
		logic [29:0] value;
		logic        not_ready;
	} answer_t;

	// The predictor's own copy of the block state.
	logic [29:0] fact_tab [DEPTH];
	logic [29:0] inv_fact_tab [DEPTH];
	bit          built;

	answer_t pending_answers[$];
	int unsigned error_count;
	int unsigned burst_left;
	int unsigned stall_mode;

	// Clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [29:0] mod_mul(logic [29:0] a, logic [29:0] b);
		longint unsigned prod;
		prod = longint'(a) * longint'(b);
		return 30'(prod % longint'(MODULUS));
	endfunction

	// The top inverse factorial comes from Fermat's little theorem:
	// it is the top factorial raised to the power p-2.
	function automatic logic [29:0] mod_pow(logic [29:0] base, logic [29:0] e);
		logic [29:0] acc;
		logic [29:0] sq;
		acc = 30'd1;
		sq = base;
		while (e != 0) begin
			if (e[0])
				acc = mod_mul(acc, sq);
			sq = mod_mul(sq, sq);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic void fill_tables();
		fact_tab[0] = 30'd1;
		for (int i = 1; i < DEPTH; i++)
			fact_tab[i] = mod_mul(fact_tab[i-1], 30'(i));
		inv_fact_tab[DEPTH-1] = mod_pow(fact_tab[DEPTH-1], FERMAT_EXP);
		for (int i = DEPTH - 1; i >= 1; i--)
			inv_fact_tab[i-1] = mod_mul(inv_fact_tab[i], 30'(i));
	endfunction

	// Expected answer for one accepted word. This also updates the
	// predictor's view of whether the tables have been built.
	function automatic answer_t predict_answer(req_t req, logic [11:0] n, logic [11:0] k);
		answer_t a;
		a = '0;
		case (req)
			REQ_BUILD: begin
				built = 1'b1;
			end
			REQ_COMB, REQ_PERM: begin
				if (!built) begin
					a.not_ready = 1'b1;
				end else if (k <= n) begin
					a.value = mod_mul(mod_mul(fact_tab[n], inv_fact_tab[k]),
						inv_fact_tab[n-k]);
					if (req == REQ_PERM)
						a.value = mod_mul(a.value, fact_tab[k]);
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	// Sends one word. The sender works in bursts: after each burst it pauses
	// for a random number of cycles, sometimes none. Now and then a burst of
	// 200 words gives a long stretch with no pauses at all.
	task automatic send_word(req_t req, logic [11:0] n, logic [11:0] k);
		int unsigned gap;
		answer_t expected;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			for (int i = 0; i < gap; i++) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		n_value <= n;
		k_value <= k;
		do
			@(posedge clk);
		while (in_stall);
		expected = predict_answer(req, n, k);
		pending_answers = {pending_answers, expected};
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Waits until every predicted word has come back.
	task automatic wait_drained();
		go_quiet();
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_query();
		logic [11:0] n;
		logic [11:0] k;
		int unsigned pick;
		req_t req;
		pick = $urandom_range(0, 19);
		req = (pick == 0) ? REQ_NONE : (pick < 10) ? REQ_COMB : REQ_PERM;
		n = 12'($urandom);
		// Most words keep k within n; about a quarter draw k at random, so
		// about one word in eight has k greater than n.
		if ($urandom_range(0, 3) == 0)
			k = 12'($urandom);
		else
			k = 12'($urandom_range(0, n));
		send_word(req, n, k);
	endtask

	// Before the first build, every query must report that the tables are
	// not ready. The unused request code must still return a plain zero.
	task automatic test_before_build();
		send_word(REQ_COMB, 12'd5, 12'd2);
		send_word(REQ_PERM, 12'd4095, 12'd0);
		send_word(REQ_NONE, 12'd4095, 12'd4095);
		send_word(REQ_COMB, 12'd0, 12'd4095);
	endtask

	// The build word ignores n and k, so all-ones values are sent with it.
	task automatic test_first_build();
		send_word(REQ_BUILD, 12'hFFF, 12'hFFF);
	endtask

	// Field extremes and special cases: empty choices, full choices, the
	// table top, k just above n, and the unused code after the build.
	task automatic test_edges();
		send_word(REQ_COMB, 12'd0, 12'd0);
		send_word(REQ_PERM, 12'd0, 12'd0);
		send_word(REQ_COMB, 12'd4095, 12'd4095);
		send_word(REQ_PERM, 12'd4095, 12'd4095);
		send_word(REQ_COMB, 12'd4095, 12'd0);
		send_word(REQ_PERM, 12'd4095, 12'd0);
		send_word(REQ_COMB, 12'd4095, 12'd2048);
		send_word(REQ_PERM, 12'd4095, 12'd1);
		send_word(REQ_COMB, 12'd10, 12'd11);
		send_word(REQ_PERM, 12'd0, 12'd4095);
		send_word(REQ_COMB, 12'd1, 12'd1);
		send_word(REQ_PERM, 12'd2730, 12'd1365);
		send_word(REQ_NONE, 12'd100, 12'd3);
		send_word(REQ_NONE, 12'd0, 12'd0);
	endtask

	task automatic test_random_queries(int unsigned count);
		for (int i = 0; i < count; i++)
			send_random_query();
	endtask

	// The sender holds off until every result has been returned. It then
	// restarts with a burst against a fully empty block.
	task automatic test_drain_pause();
		wait_drained();
		test_random_queries(30);
	endtask

	// A repeated build must rewrite the same contents, so earlier answers
	// must still hold afterward.
	task automatic test_rebuild();
		send_word(REQ_BUILD, 12'h000, 12'h000);
		send_word(REQ_COMB, 12'd4095, 12'd2048);
		send_word(REQ_PERM, 12'd4095, 12'd4095);
		test_random_queries(20);
	endtask

	// The receiver switches among several stall patterns: never, at random,
	// in long runs, and nearly always.
	always @(negedge clk) begin
		if ($urandom_range(0, 149) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 8) ? out_stall : ~out_stall;
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// Checks each accepted output word against the oldest prediction.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("output word with no prediction waiting");
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (result_value !== want.value) begin
					$error("result_value expected %0d actual %0d", want.value, result_value);
					error_count++;
				end
				if (status !== want.not_ready) begin
					$error("status expected %0d actual %0d", want.not_ready, status);
					error_count++;
				end
			end
		end
	end

	initial begin
		int unsigned drain_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_NONE;
		n_value = '0;
		k_value = '0;
		out_stall = 1'b0;
		stall_mode = 0;
		built = 1'b0;
		burst_left = 0;
		error_count = 0;
		fill_tables();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_before_build();
		test_first_build();
		test_edges();
		test_random_queries(700);
		test_drain_pause();
		test_random_queries(650);
		test_rebuild();

		wait_drained();
		drain_cycles = 0;
		while (drain_cycles < 300) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (error_count == 0 && pending_answers.size() == 0)
			$display("binomial_permutation_mod_prime regression: pass");
		else
			$display("binomial_permutation_mod_prime regression: fail");
		$finish;
	end

	// Time limit for the whole run. The slowest correct run needs two builds,
	// each a walk of the full table, plus about 1450 words, with sender gaps and
	// output stalls adding waits to the words. That is under 2 ms, and the limit
	// allows many times as much.
	initial begin
		#40ms;
		$display("binomial_permutation_mod_prime regression: fail");
		$finish;
	end

endmodule
